// File: rtl/bsc_pkg.sv
// bsc_pkg: shared widths, calibration constants and register indexes
// for the barometric compensation core. No dependencies.

package bsc_pkg;

  localparam int RawW   = 24;
  localparam int CoefW  = 16;
  localparam int TempW  = 19;
  localparam int PresW  = 22;
  localparam int RegIdxW = 3;

  // shift amounts of the first-order formulas
  localparam int RefShift       = 8;
  localparam int TempShift      = 23;
  localparam int OffBaseShift   = 16;
  localparam int OffShift       = 7;
  localparam int SensBaseShift  = 15;
  localparam int SensShift      = 8;
  localparam int PresProdShift  = 21;
  localparam int PresFinalShift = 15;

  localparam logic signed [TempW-1:0] TempBase = 19'sd2000;

  typedef enum logic [RegIdxW-1:0] {
    REG_C1 = 3'd0,
    REG_C2 = 3'd1,
    REG_C3 = 3'd2,
    REG_C4 = 3'd3,
    REG_C5 = 3'd4,
    REG_C6 = 3'd5
  } reg_idx_t;

endpackage

// File: rtl/baro_sensor_compensation_core.sv
// baro_sensor_compensation_core: first-order pressure and temperature
// compensation in a six-stage pipeline. Depends on bsc_pkg.
//
//  channel  | handshake        | payload
//  ---------+------------------+----------------------------------------
//  input    | start, busy      | raw_pressure, raw_temperature
//  result   | done (strobe)    | temperature_centi, pressure_pa
//  config   | cfg_we           | cfg_index, cfg_data
//
// an accepted item moves through stages 1 to 6, the last being the output
// register; one item can be accepted every cycle, set by the pipeline of
// 25x17 and 25x17/24x17 partial-product multipliers
// busy is held low, so an item is accepted whenever start is high
// rst is synchronous and clears the coefficients and the valid bits
// the receiver cannot stall: done is high for exactly one cycle per item

module baro_sensor_compensation_core
  import bsc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [RawW-1:0]           raw_pressure,
  input  logic [RawW-1:0]           raw_temperature,
  input  logic                      cfg_we,
  input  logic [RegIdxW-1:0]        cfg_index,
  input  logic [CoefW-1:0]          cfg_data,
  output logic                      done,
  output logic signed [TempW-1:0]   temperature_centi,
  output logic signed [PresW-1:0]   pressure_pa
);

  logic [CoefW-1:0] c1, c2, c3, c4, c5, c6;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
      c2 <= '0;
      c3 <= '0;
      c4 <= '0;
      c5 <= '0;
      c6 <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_C1: c1 <= cfg_data;
        REG_C2: c2 <= cfg_data;
        REG_C3: c3 <= cfg_data;
        REG_C4: c4 <= cfg_data;
        REG_C5: c5 <= cfg_data;
        REG_C6: c6 <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic accept;
  assign accept = start & ~busy;

  // valid bits, one per stage
  logic [5:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[4:0], accept};
    end
  end

  // stage 1: temperature difference
  logic signed [RawW:0] dt_next;
  logic signed [RawW:0] s1_dt;
  logic [RawW-1:0]      s1_d1;

  assign dt_next = $signed({1'b0, raw_temperature})
                 - $signed({1'b0, c5, {RefShift{1'b0}}});

  always_ff @(posedge clk) begin
    s1_dt <= dt_next;
    s1_d1 <= raw_pressure;
  end

  // stage 2: the three coefficient products
  localparam int ProdW = RawW + 1 + CoefW + 1;
  logic signed [ProdW-1:0] s2_tprod, s2_oprod, s2_sprod;
  logic [RawW-1:0]         s2_d1;

  always_ff @(posedge clk) begin
    s2_tprod <= s1_dt * $signed({1'b0, c6});
    s2_oprod <= s1_dt * $signed({1'b0, c4});
    s2_sprod <= s1_dt * $signed({1'b0, c3});
    s2_d1    <= s1_d1;
  end

  // stage 3: temperature, offset and sensitivity
  localparam int OffW  = ProdW - OffShift + 1;
  localparam int SensW = ProdW - SensShift;
  logic signed [TempW-1:0] temp_next;
  logic signed [OffW-1:0]  off_next;
  logic signed [SensW-1:0] sens_next;
  logic signed [TempW-1:0] s3_temp;
  logic signed [OffW-1:0]  s3_off;
  logic signed [SensW-1:0] s3_sens;
  logic [RawW-1:0]         s3_d1;

  assign temp_next = $signed(s2_tprod[ProdW-1:TempShift]) + TempBase;
  assign off_next  = $signed({s2_oprod[ProdW-1], s2_oprod[ProdW-1:OffShift]})
                   + $signed({{(OffW-CoefW-OffBaseShift){1'b0}}, c2,
                              {OffBaseShift{1'b0}}});
  assign sens_next = $signed(s2_sprod[ProdW-1:SensShift])
                   + $signed({{(SensW-CoefW-SensBaseShift){1'b0}}, c1,
                              {SensBaseShift{1'b0}}});

  always_ff @(posedge clk) begin
    s3_temp <= temp_next;
    s3_off  <= off_next;
    s3_sens <= sens_next;
    s3_d1   <= s2_d1;
  end

  // stage 4: d1 * sens as two partial products
  localparam int LoW   = 17;
  localparam int HiW   = SensW - LoW;
  localparam int PloW  = RawW + LoW;
  localparam int PhiW  = RawW + 1 + HiW;
  logic [PloW-1:0]         s4_plo;
  logic signed [PhiW-1:0]  s4_phi;
  logic signed [TempW-1:0] s4_temp;
  logic signed [OffW-1:0]  s4_off;

  always_ff @(posedge clk) begin
    s4_plo  <= s3_d1 * s3_sens[LoW-1:0];
    s4_phi  <= $signed({1'b0, s3_d1}) * $signed(s3_sens[SensW-1:LoW]);
    s4_temp <= s3_temp;
    s4_off  <= s3_off;
  end

  // stage 5: combine partials and drop the low product bits
  localparam int FullW = PhiW + LoW;
  localparam int P21W  = FullW - PresProdShift;
  logic signed [FullW-1:0] full_prod;
  logic signed [P21W-1:0]  s5_p21;
  logic signed [TempW-1:0] s5_temp;
  logic signed [OffW-1:0]  s5_off;

  assign full_prod = $signed({s4_phi, {LoW{1'b0}}})
                   + $signed({{(FullW-PloW){1'b0}}, s4_plo});

  always_ff @(posedge clk) begin
    s5_p21  <= full_prod[FullW-1:PresProdShift];
    s5_temp <= s4_temp;
    s5_off  <= s4_off;
  end

  // stage 6: subtract offset, final floor shift, output register
  localparam int DiffW = P21W + 1;
  logic signed [DiffW-1:0] diff;

  assign diff = $signed({s5_p21[P21W-1], s5_p21})
              - $signed({{(DiffW-OffW){s5_off[OffW-1]}}, s5_off});

  always_ff @(posedge clk) begin
    temperature_centi <= s5_temp;
    pressure_pa       <= diff[PresFinalShift+PresW-1:PresFinalShift];
  end

  assign done = vld[5];

endmodule
